FILE: rtl/csv_column_type_profiler_macros.svh
// Assertion macros shared by the checker.
`ifndef CSV_COLUMN_TYPE_PROFILER_MACROS_SVH
`define CSV_COLUMN_TYPE_PROFILER_MACROS_SVH
`define CCTP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CCTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/cctp_pkg.sv
package cctp_pkg;
  typedef enum logic [4:0] {
    G_WS, G_SIGN, G_ZERO, G_INT, G_DOT0, G_FRAC, G_EXP, G_EXPS, G_EXPD,
    G_HX, G_HINT, G_HDOT0, G_HFRAC, G_HP, G_HPS, G_HPD,
    G_I, G_IN, G_INF, G_INFI, G_INFIN, G_INFINI, G_INFINIT, G_INFINITY,
    G_N, G_NA, G_NAN, G_NANP, G_NANC, G_BAD
  } gstate_t;

  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_FLOAT = 2'd1;
  localparam logic [1:0] KIND_TEXT  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [63:0] MAG_STEP_LIMIT = 64'd922337203685477580;
  localparam logic [63:0] MAG_NEG_MAX    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_POS_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic       valid;
    logic [5:0] column_index;
    logic       header_row;
    logic [15:0] cell_length;
    logic [1:0] cell_kind;
    logic       row_end;
    logic       column_ignored;
  } cell_t;

  function automatic gstate_t mant_begin(input logic [7:0] ch, input logic [7:0] lc,
                                         input logic dig);
    gstate_t r;
    r = G_BAD;
    if (ch == 8'h30) r = G_ZERO;
    else if (dig) r = G_INT;
    else if (ch == 8'h2E) r = G_DOT0;
    else if (lc == 8'h69) r = G_I;
    else if (lc == 8'h6E) r = G_N;
    return r;
  endfunction

  function automatic gstate_t gnext(input gstate_t g, input logic [7:0] ch);
    logic [7:0] lc;
    logic dig, hexd, sp, sgn, alnum;
    gstate_t nx;
    lc = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'd32 : ch;
    dig = ch >= 8'h30 && ch <= 8'h39;
    hexd = dig || (lc >= 8'h61 && lc <= 8'h66);
    sp = ch == 8'h20 || (ch >= 8'd9 && ch <= 8'd13);
    sgn = ch == 8'h2B || ch == 8'h2D;
    alnum = dig || (lc >= 8'h61 && lc <= 8'h7A) || ch == 8'h5F;
    nx = G_BAD;
    case (g)
      G_WS: begin
        if (sp) nx = G_WS;
        else if (sgn) nx = G_SIGN;
        else nx = mant_begin(ch, lc, dig);
      end
      G_SIGN: nx = mant_begin(ch, lc, dig);
      G_ZERO, G_INT: begin
        if (dig) nx = G_INT;
        else if (ch == 8'h2E) nx = G_FRAC;
        else if (lc == 8'h65) nx = G_EXP;
        else if (g == G_ZERO && lc == 8'h78) nx = G_HX;
      end
      G_DOT0: if (dig) nx = G_FRAC;
      G_FRAC: begin
        if (dig) nx = G_FRAC;
        else if (lc == 8'h65) nx = G_EXP;
      end
      G_EXP: begin
        if (sgn) nx = G_EXPS;
        else if (dig) nx = G_EXPD;
      end
      G_EXPS, G_EXPD: if (dig) nx = G_EXPD;
      G_HX: begin
        if (hexd) nx = G_HINT;
        else if (ch == 8'h2E) nx = G_HDOT0;
      end
      G_HINT: begin
        if (hexd) nx = G_HINT;
        else if (ch == 8'h2E) nx = G_HFRAC;
        else if (lc == 8'h70) nx = G_HP;
      end
      G_HDOT0: if (hexd) nx = G_HFRAC;
      G_HFRAC: begin
        if (hexd) nx = G_HFRAC;
        else if (lc == 8'h70) nx = G_HP;
      end
      G_HP: begin
        if (sgn) nx = G_HPS;
        else if (dig) nx = G_HPD;
      end
      G_HPS, G_HPD: if (dig) nx = G_HPD;
      G_I: if (lc == 8'h6E) nx = G_IN;
      G_IN: if (lc == 8'h66) nx = G_INF;
      G_INF: if (lc == 8'h69) nx = G_INFI;
      G_INFI: if (lc == 8'h6E) nx = G_INFIN;
      G_INFIN: if (lc == 8'h69) nx = G_INFINI;
      G_INFINI: if (lc == 8'h74) nx = G_INFINIT;
      G_INFINIT: if (lc == 8'h79) nx = G_INFINITY;
      G_N: if (lc == 8'h61) nx = G_NA;
      G_NA: if (lc == 8'h6E) nx = G_NAN;
      G_NAN: if (ch == 8'h28) nx = G_NANP;
      G_NANP: begin
        if (alnum) nx = G_NANP;
        else if (ch == 8'h29) nx = G_NANC;
      end
      default: nx = G_BAD;
    endcase
    return nx;
  endfunction
endpackage

FILE: rtl/cctp_ram.sv
module cctp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/csv_column_type_profiler.sv
// CSV column profiler.
// The input channel takes one byte word per handshake together with the
// first_of_stream and last_of_stream flags. The output channel returns one
// word per closed cell: at a comma outside quotes, at LF, and at the end of a
// stream, so an input word yields zero, one or two output words.
// A cell passes a byte stage that parses and classifies it, a lookup stage
// that gets its column table entry from a memory, merges the cell and writes
// the table back, and a queue stage that puts the word into a four-entry
// output queue. The second cell of a word that closes two cells follows the
// first into the stages in the cycle after. Back-to-back cells of the same
// column are forwarded from the queue stage.
// One input word is taken per cycle while the receiver keeps up; a word that
// closes two cells holds the input while its second cell enters the stages.
// in_ready is low while the cells in the stages and the queue plus two more
// could overfill the four places of the queue, so a stalled receiver stops
// intake after a few cells, and nothing is lost.
// Reset and first_of_stream clear the per-column valid bits, so the column
// table needs no clearing pass.
module csv_column_type_profiler #(
  parameter int MAX_COLUMNS = 64,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_stream,
  input  logic        in_last_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_column_index,
  output logic        out_header_row,
  output logic [15:0] out_cell_length,
  output logic [1:0]  out_cell_kind,
  output logic [15:0] out_column_width,
  output logic [1:0]  out_column_kind,
  output logic        out_row_end,
  output logic        out_column_ignored
);
  import cctp_pkg::*;

  localparam int CB = $clog2(MAX_COLUMNS + 1);
  localparam int AB = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LB = LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
  localparam logic [CB-1:0] COL_MAX = CB'(MAX_COLUMNS);
  localparam int RW = LB + 2;

  typedef struct packed {
    logic          valid;
    logic [CB-1:0] col;
    logic          hdr;
    logic [LB-1:0] len;
    logic [1:0]    kind;
    logic          row_end;
    logic          ign;
  } ccell_t;

  logic quoting_r, quoting_nxt, qpend_r, qpend_nxt, in_hdr_r, in_hdr_nxt;
  logic [CB-1:0] col_r, col_nxt, hcols_r, hcols_nxt;
  gstate_t g_r, g_nxt;
  logic isp_r, isp_nxt;
  logic [LB-1:0] raw_r, raw_nxt, trim_r, trim_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic ovf_r, ovf_nxt, neg_r, neg_nxt;
  logic [MAX_COLUMNS-1:0] vld_r;

  logic held_r, held_nxt;
  ccell_t held_cell_r, held_cell_nxt;
  ccell_t s1_r, s1_nxt, s2_r;
  logic [LB-1:0] s2_w_r;
  logic [1:0] s2_k_r;

  ccell_t q_r [4];
  logic [LB-1:0] qw_r [4];
  logic [1:0] qk_r [4];
  logic [2:0] qcnt_r;
  logic [1:0] q_rd_r, q_wr_r;

  logic acc;
  logic pop;
  logic [7:0] ch;
  ccell_t c0, c1;

  function automatic logic [1:0] classify(input gstate_t g, input logic [LB-1:0] raw,
                                          input logic [63:0] mag, input logic ovf,
                                          input logic neg);
    logic [1:0] k;
    if (raw == '0) k = KIND_EMPTY;
    else if ((g == G_ZERO || g == G_INT) && !ovf &&
             mag <= (neg ? MAG_NEG_MAX : MAG_POS_MAX)) k = KIND_INT;
    else if (g == G_ZERO || g == G_INT || g == G_FRAC || g == G_EXPD ||
             g == G_HINT || g == G_HFRAC || g == G_HPD || g == G_INF ||
             g == G_INFINITY || g == G_NAN || g == G_NANC) k = KIND_FLOAT;
    else k = KIND_TEXT;
    return k;
  endfunction

  assign pop = out_valid && out_ready;

  // Space for the worst case in flight: two stages and the queue, plus two new cells.
  logic [2:0] inflight;
  assign inflight = qcnt_r + 3'(s1_r.valid) + 3'(s2_r.valid);
  assign in_ready = !held_r && (inflight <= 3'd2 || (inflight == 3'd3 && pop));
  assign acc = in_valid && in_ready;
  assign ch = in_data_byte;

  always_comb begin
    logic q0, q1, qp, ih, consumed, blank, take, spfeed, close0, close1;
    logic [CB-1:0] col, hc, limit;
    gstate_t g, gn;
    logic isp, ovf, neg;
    logic [LB-1:0] raw, trim;
    logic [63:0] mag, m10;
    logic [7:0] fch;
    quoting_nxt = quoting_r; qpend_nxt = qpend_r; in_hdr_nxt = in_hdr_r;
    col_nxt = col_r; hcols_nxt = hcols_r; g_nxt = g_r; isp_nxt = isp_r;
    raw_nxt = raw_r; trim_nxt = trim_r; mag_nxt = mag_r; ovf_nxt = ovf_r;
    neg_nxt = neg_r;
    held_nxt = held_r; held_cell_nxt = held_cell_r;
    c0 = '0; c1 = '0;
    q0 = quoting_r; qp = qpend_r; ih = in_hdr_r; col = col_r; hc = hcols_r;
    g = g_r; isp = isp_r; raw = raw_r; trim = trim_r; mag = mag_r;
    ovf = ovf_r; neg = neg_r;
    consumed = 1'b0; take = 1'b0; close0 = 1'b0; close1 = 1'b0; blank = 1'b0;
    q1 = q0; gn = g; spfeed = 1'b0; fch = ch; m10 = '0; limit = '0;
    if (held_r) begin
      held_nxt = 1'b0;
    end
    if (acc) begin
      if (in_first_of_stream) begin
        q0 = 1'b0; qp = 1'b0; ih = 1'b1; col = '0; hc = '0;
        g = G_WS; isp = 1'b0; raw = '0; trim = '0; mag = '0; ovf = 1'b0; neg = 1'b0;
      end
      q1 = q0;
      if (qp) begin
        qp = 1'b0;
        if (ch == CH_QUOTE) begin
          take = 1'b1; consumed = 1'b1;
        end else begin
          q1 = 1'b0;
        end
      end
      if (!consumed) begin
        if (ch == CH_LF) begin
          q1 = 1'b0; close0 = 1'b1;
        end else if (ch == CH_QUOTE) begin
          if (q1) qp = 1'b1;
          else q1 = 1'b1;
        end else if (ch == CH_COMMA && !q1) begin
          close0 = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      if (take) begin
        blank = ch == 8'h20 || ch == 8'h09 || ch == 8'h0D || ch == CH_LF;
        if (raw == '0 && blank) begin
        end else begin
          raw = (raw < LEN_MAX) ? raw + 1'b1 : raw;
          if (blank) begin
            isp = 1'b1;
          end else begin
            trim = raw;
            // An interior blank run drives the grammar with one space,
            // which only ever leaves G_WS in place or reaches G_BAD.
            spfeed = isp;
            isp = 1'b0;
            if (spfeed) gn = gnext(g, 8'h20);
            else gn = g;
            if (gn == G_WS && (ch == 8'h2B || ch == 8'h2D)) neg = (ch == 8'h2D);
            g = gnext(gn, fch);
            if ((g == G_ZERO || g == G_INT) && !ovf) begin
              if (mag > MAG_STEP_LIMIT) begin
                ovf = 1'b1;
              end else begin
                m10 = (mag << 3) + (mag << 1) + 64'(ch - 8'h30);
                mag = m10;
                if (m10 > MAG_NEG_MAX) ovf = 1'b1;
              end
            end
          end
        end
      end
      if (close0) begin
        limit = ih ? COL_MAX : hc;
        c0.valid = 1'b1; c0.col = col; c0.hdr = ih; c0.len = trim;
        c0.kind = classify(g, raw, mag, ovf, neg);
        c0.row_end = (ch == CH_LF); c0.ign = (col >= limit) || (col >= COL_MAX);
        if (ch == CH_LF) begin
          if (ih) begin
            hc = (col < COL_MAX) ? col + 1'b1 : COL_MAX; ih = 1'b0;
          end
          col = '0;
        end else begin
          col = (col < COL_MAX) ? col + 1'b1 : COL_MAX;
        end
        g = G_WS; isp = 1'b0; raw = '0; trim = '0; mag = '0; ovf = 1'b0; neg = 1'b0;
      end
      if (in_last_of_stream && ch != CH_LF) begin
        q1 = 1'b0; qp = 1'b0; close1 = 1'b1;
        limit = ih ? COL_MAX : hc;
        c1.valid = 1'b1; c1.col = col; c1.hdr = ih; c1.len = trim;
        c1.kind = classify(g, raw, mag, ovf, neg);
        c1.row_end = 1'b1; c1.ign = (col >= limit) || (col >= COL_MAX);
        if (ih) begin
          hc = (col < COL_MAX) ? col + 1'b1 : COL_MAX; ih = 1'b0;
        end
        col = '0;
        g = G_WS; isp = 1'b0; raw = '0; trim = '0; mag = '0; ovf = 1'b0; neg = 1'b0;
      end
      quoting_nxt = q1; qpend_nxt = qp; in_hdr_nxt = ih; col_nxt = col;
      hcols_nxt = hc; g_nxt = g; isp_nxt = isp; raw_nxt = raw; trim_nxt = trim;
      mag_nxt = mag; ovf_nxt = ovf; neg_nxt = neg;
      if (close0 && close1) begin
        held_nxt = 1'b1; held_cell_nxt = c1;
      end
    end
    if (held_r) s1_nxt = held_cell_r;
    else if (close0) s1_nxt = c0;
    else if (close1) s1_nxt = c1;
    else s1_nxt = '0;
  end

  // Table entry: width and kind. An entry without its valid bit reads as zero.
  logic [RW-1:0] rd_data, wr_data;
  logic wr_en;
  logic [AB-1:0] wr_addr;
  logic [LB-1:0] base_w, new_w;
  logic [1:0] base_k, new_k;
  logic fwd;

  cctp_ram #(.WIDTH(RW), .DEPTH(MAX_COLUMNS)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (s1_nxt.col[AB-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    fwd = s2_r.valid && !s2_r.ign && s2_r.col == s1_r.col;
    if (s1_r.hdr) begin
      base_w = '0; base_k = KIND_INT;
    end else if (fwd) begin
      base_w = s2_w_r; base_k = s2_k_r;
    end else if (vld_r[s1_r.col[AB-1:0]]) begin
      base_w = rd_data[LB+1:2]; base_k = rd_data[1:0];
    end else begin
      base_w = '0; base_k = KIND_INT;
    end
    new_w = base_w; new_k = base_k;
    if (!s1_r.hdr && s1_r.kind != KIND_EMPTY) begin
      if (s1_r.len > base_w) new_w = s1_r.len;
      if (s1_r.kind > base_k) new_k = s1_r.kind;
    end
    wr_en = s1_r.valid && !s1_r.ign && !s1_r.hdr && s1_r.kind != KIND_EMPTY;
    wr_addr = s1_r.col[AB-1:0];
    wr_data = {new_w, new_k};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quoting_r <= 1'b0; qpend_r <= 1'b0; in_hdr_r <= 1'b1;
      col_r <= '0; hcols_r <= '0; g_r <= G_WS; isp_r <= 1'b0;
      raw_r <= '0; trim_r <= '0; mag_r <= '0; ovf_r <= 1'b0; neg_r <= 1'b0;
      vld_r <= '0; held_r <= 1'b0; s1_r <= '0; s2_r <= '0;
      qcnt_r <= '0; q_rd_r <= '0; q_wr_r <= '0;
    end else begin
      quoting_r <= quoting_nxt; qpend_r <= qpend_nxt; in_hdr_r <= in_hdr_nxt;
      col_r <= col_nxt; hcols_r <= hcols_nxt; g_r <= g_nxt; isp_r <= isp_nxt;
      raw_r <= raw_nxt; trim_r <= trim_nxt; mag_r <= mag_nxt; ovf_r <= ovf_nxt;
      neg_r <= neg_nxt; held_r <= held_nxt;
      s1_r <= s1_nxt; s2_r <= s1_r;
      if (acc && in_first_of_stream) vld_r <= '0;
      else if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (s2_r.valid) begin
        q_r[q_wr_r] <= s2_r;
        q_wr_r <= q_wr_r + 2'd1;
      end
      if (pop) q_rd_r <= q_rd_r + 2'd1;
      qcnt_r <= qcnt_r + 3'(s2_r.valid) - 3'(pop);
    end
    held_cell_r <= held_cell_nxt;
    if (s1_r.valid) begin
      s2_w_r <= s1_r.ign ? '0 : new_w;
      s2_k_r <= s1_r.ign ? KIND_INT : new_k;
    end
    if (s2_r.valid) begin
      qw_r[q_wr_r] <= s2_w_r;
      qk_r[q_wr_r] <= s2_k_r;
    end
  end

  assign out_valid          = qcnt_r != 3'd0;
  assign out_column_index   = 6'(q_r[q_rd_r].col);
  assign out_header_row     = q_r[q_rd_r].hdr;
  assign out_cell_length    = 16'(q_r[q_rd_r].len);
  assign out_cell_kind      = q_r[q_rd_r].kind;
  assign out_column_width   = 16'(qw_r[q_rd_r]);
  assign out_column_kind    = qk_r[q_rd_r];
  assign out_row_end        = q_r[q_rd_r].row_end;
  assign out_column_ignored = q_r[q_rd_r].ign;
endmodule

FILE: rtl/cctp_checker.sv
`include "csv_column_type_profiler_macros.svh"
module cctp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_cell_kind,
  input logic [15:0] out_column_width,
  input logic [1:0]  out_column_kind,
  input logic        out_header_row,
  input logic        out_column_ignored
);
  import cctp_pkg::*;

  `CCTP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
    $stable(out_cell_kind) && $stable(out_column_width) && $stable(out_column_kind) && $stable(out_header_row) && $stable(out_column_ignored),
    "output word changed while stalled")
  `CCTP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid,
    "output word dropped while stalled")
  `CCTP_ASSERT_IMPL(a_hdr_zero, clk, rst_n, out_valid && (out_header_row || out_column_ignored),
    out_column_width == 16'd0 && out_column_kind == KIND_INT,
    "header or ignored cell shows column statistics")
  `CCTP_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, out_column_kind != KIND_EMPTY,
    "column kind out of range")
endmodule

bind csv_column_type_profiler cctp_checker u_cctp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_cell_kind      (out_cell_kind),
  .out_column_width   (out_column_width),
  .out_column_kind    (out_column_kind),
  .out_header_row     (out_header_row),
  .out_column_ignored (out_column_ignored)
);

FILE: tb/csv_column_type_profiler_tb.sv
module csv_column_type_profiler_tb;
  import cctp_pkg::*;

  typedef struct {
    logic [5:0]  column_index;
    logic        header_row;
    logic [15:0] cell_length;
    logic [1:0]  cell_kind;
    logic [15:0] column_width;
    logic [1:0]  column_kind;
    logic        row_end;
    logic        column_ignored;
  } cell_word_t;

  localparam int NCOL = 64;
  localparam int LEN_SAT = 65535;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_data_byte;
  logic in_first_of_stream;
  logic in_last_of_stream;
  logic out_valid;
  logic out_ready;
  logic [5:0] out_column_index;
  logic out_header_row;
  logic [15:0] out_cell_length;
  logic [1:0] out_cell_kind;
  logic [15:0] out_column_width;
  logic [1:0] out_column_kind;
  logic out_row_end;
  logic out_column_ignored;

  csv_column_type_profiler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_byte(in_data_byte),
    .in_first_of_stream(in_first_of_stream), .in_last_of_stream(in_last_of_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_column_index(out_column_index), .out_header_row(out_header_row),
    .out_cell_length(out_cell_length), .out_cell_kind(out_cell_kind),
    .out_column_width(out_column_width), .out_column_kind(out_column_kind),
    .out_row_end(out_row_end), .out_column_ignored(out_column_ignored)
  );

  // Profiler state mirrored by the predictor.
  bit quoting, quote_pend, in_hdr, space_inside, neg, ovf;
  int unsigned cur_col, hdr_cols, raw_len, trim_len, lead_cnt;
  gstate_t gst;
  logic [63:0] mag;
  int unsigned width_tab[NCOL];
  logic [1:0] kind_tab[NCOL];

  cell_word_t expected_cells[$];
  int errors;
  int cells_seen;
  int hold_cycles;
  bit stress_on;

  function automatic int unsigned sat_inc(int unsigned x);
    return x < LEN_SAT ? x + 1 : x;
  endfunction

  function automatic void clear_cell();
    raw_len = 0; trim_len = 0; lead_cnt = 0; space_inside = 0; gst = G_WS;
    mag = 0; ovf = 0; neg = 0;
  endfunction

  function automatic void clear_stream();
    quoting = 0; quote_pend = 0; in_hdr = 1; cur_col = 0; hdr_cols = 0;
    clear_cell();
    for (int i = 0; i < NCOL; i++) begin
      width_tab[i] = 0;
      kind_tab[i] = KIND_INT;
    end
  endfunction

  function automatic gstate_t mant_start(logic [7:0] c, logic [7:0] l, bit d);
    if (c == "0") return G_ZERO;
    if (d) return G_INT;
    if (c == ".") return G_DOT0;
    if (l == "i") return G_I;
    if (l == "n") return G_N;
    return G_BAD;
  endfunction

  function automatic void number_step(logic [7:0] c);
    logic [7:0] l;
    bit d, hx, sp, sg;
    gstate_t nx;
    l = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    d = c >= "0" && c <= "9";
    hx = d || (l >= "a" && l <= "f");
    sp = c == " " || (c >= 9 && c <= 13);
    sg = c == "+" || c == "-";
    nx = G_BAD;
    case (gst)
      G_WS: begin
        if (sp) nx = G_WS;
        else if (sg) begin
          neg = c == "-";
          nx = G_SIGN;
        end else nx = mant_start(c, l, d);
      end
      G_SIGN: nx = mant_start(c, l, d);
      G_ZERO, G_INT: begin
        if (d) nx = G_INT;
        else if (c == ".") nx = G_FRAC;
        else if (l == "e") nx = G_EXP;
        else if (gst == G_ZERO && l == "x") nx = G_HX;
      end
      G_DOT0: if (d) nx = G_FRAC;
      G_FRAC: begin
        if (d) nx = G_FRAC;
        else if (l == "e") nx = G_EXP;
      end
      G_EXP: begin
        if (sg) nx = G_EXPS;
        else if (d) nx = G_EXPD;
      end
      G_EXPS, G_EXPD: if (d) nx = G_EXPD;
      G_HX: begin
        if (hx) nx = G_HINT;
        else if (c == ".") nx = G_HDOT0;
      end
      G_HINT: begin
        if (hx) nx = G_HINT;
        else if (c == ".") nx = G_HFRAC;
        else if (l == "p") nx = G_HP;
      end
      G_HDOT0: if (hx) nx = G_HFRAC;
      G_HFRAC: begin
        if (hx) nx = G_HFRAC;
        else if (l == "p") nx = G_HP;
      end
      G_HP: begin
        if (sg) nx = G_HPS;
        else if (d) nx = G_HPD;
      end
      G_HPS, G_HPD: if (d) nx = G_HPD;
      G_I: if (l == "n") nx = G_IN;
      G_IN: if (l == "f") nx = G_INF;
      G_INF: if (l == "i") nx = G_INFI;
      G_INFI: if (l == "n") nx = G_INFIN;
      G_INFIN: if (l == "i") nx = G_INFINI;
      G_INFINI: if (l == "t") nx = G_INFINIT;
      G_INFINIT: if (l == "y") nx = G_INFINITY;
      G_N: if (l == "a") nx = G_NA;
      G_NA: if (l == "n") nx = G_NAN;
      G_NAN: if (c == "(") nx = G_NANP;
      G_NANP: begin
        if (d || (l >= "a" && l <= "z") || c == "_") nx = G_NANP;
        else if (c == ")") nx = G_NANC;
      end
      default: nx = G_BAD;
    endcase
    if ((nx == G_ZERO || nx == G_INT) && d && !ovf) begin
      if (mag > 64'd922337203685477580) ovf = 1;
      else begin
        mag = mag * 10 + (c - "0");
        if (mag > 64'h8000_0000_0000_0000) ovf = 1;
      end
    end
    gst = nx;
  endfunction

  function automatic void add_char(logic [7:0] c);
    bit blank;
    blank = c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    if (raw_len == 0 && blank) begin
      lead_cnt = sat_inc(lead_cnt);
      return;
    end
    raw_len = sat_inc(raw_len);
    if (blank) begin
      space_inside = 1;
      return;
    end
    trim_len = raw_len;
    if (space_inside) begin
      number_step(" ");
      space_inside = 0;
    end
    number_step(c);
  endfunction

  function automatic logic [1:0] classify();
    if (raw_len == 0) return KIND_EMPTY;
    if ((gst == G_ZERO || gst == G_INT) && !ovf &&
        mag <= (neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF))
      return KIND_INT;
    if (gst inside {G_ZERO, G_INT, G_FRAC, G_EXPD, G_HINT, G_HFRAC, G_HPD, G_INF,
                    G_INFINITY, G_NAN, G_NANC})
      return KIND_FLOAT;
    return KIND_TEXT;
  endfunction

  function automatic void close_cell(bit eol);
    cell_word_t w;
    logic [1:0] k;
    int unsigned lim;
    bit ign;
    k = classify();
    lim = in_hdr ? NCOL : hdr_cols;
    ign = cur_col >= lim || cur_col >= NCOL;
    w.column_width = 16'd0;
    w.column_kind = KIND_INT;
    if (!ign) begin
      if (!in_hdr && k != KIND_EMPTY) begin
        if (trim_len > width_tab[cur_col]) width_tab[cur_col] = trim_len;
        if (k > kind_tab[cur_col]) kind_tab[cur_col] = k;
      end
      w.column_width = 16'(width_tab[cur_col]);
      w.column_kind = kind_tab[cur_col];
    end
    w.column_index = cur_col[5:0];
    w.header_row = in_hdr;
    w.cell_length = trim_len[15:0];
    w.cell_kind = k;
    w.row_end = eol;
    w.column_ignored = ign;
    expected_cells.insert(expected_cells.size(), w);
    if (eol) begin
      if (in_hdr) begin
        hdr_cols = cur_col < NCOL ? cur_col + 1 : NCOL;
        in_hdr = 0;
      end
      cur_col = 0;
    end else cur_col = cur_col < NCOL ? cur_col + 1 : NCOL;
    clear_cell();
  endfunction

  function automatic void predict_byte(logic [7:0] c, bit first, bit last);
    bit done;
    done = 0;
    if (first) clear_stream();
    if (quote_pend) begin
      quote_pend = 0;
      if (c == CH_QUOTE) begin
        add_char(c);
        done = 1;
      end else quoting = 0;
    end
    if (!done) begin
      if (c == CH_LF) begin
        quoting = 0;
        close_cell(1);
      end else if (c == CH_QUOTE) begin
        if (quoting) quote_pend = 1;
        else quoting = 1;
      end else if (c == CH_COMMA && !quoting) close_cell(0);
      else add_char(c);
    end
    if (last && c != CH_LF) begin
      quoting = 0;
      quote_pend = 0;
      close_cell(1);
    end
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(logic [7:0] c, bit first = 0, bit last = 0, bit gaps = 1);
    int g;
    g = gaps ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0) : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data_byte <= c;
    in_first_of_stream <= first;
    in_last_of_stream <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(c, first, last);
  endtask

  task automatic send_text(string s, bit first = 0, bit last = 0);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], first && i == 0, last && i == s.len() - 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    int s;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      s = (stress_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
      if (s > 0) begin
        out_ready <= 0;
        repeat (s) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cell_word_t e;
    if (rst_n && out_valid && out_ready) begin
      cells_seen++;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected output word, column %0d", $time, out_column_index);
        errors++;
      end else begin
        e = expected_cells.pop_front();
        if (out_column_index !== e.column_index || out_header_row !== e.header_row ||
            out_cell_length !== e.cell_length || out_cell_kind !== e.cell_kind ||
            out_column_width !== e.column_width || out_column_kind !== e.column_kind ||
            out_row_end !== e.row_end || out_column_ignored !== e.column_ignored) begin
          $display("%0t: mismatch expected col=%0d hdr=%0d len=%0d kind=%0d",
                   $time, e.column_index, e.header_row, e.cell_length, e.cell_kind);
          $display("%0t:          expected w=%0d ck=%0d eol=%0d ign=%0d",
                   $time, e.column_width, e.column_kind, e.row_end, e.column_ignored);
          $display("%0t:          actual col=%0d hdr=%0d len=%0d kind=%0d",
                   $time, out_column_index, out_header_row, out_cell_length, out_cell_kind);
          $display("%0t:          actual w=%0d ck=%0d eol=%0d ign=%0d",
                   $time, out_column_width, out_column_kind, out_row_end,
                   out_column_ignored);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_text("a,\"b\"\"c\",  -12 \n", 1);
    send_text("0x1.8p3,inf,-9223372036854775808\n");
    send_text("9223372036854775808,nan(x_1), \"q\"\n");
    send_text("\013 1e5,\"open\n");
    send_text(",,,,\n");
    send_text("+.5,\"x\"", 0, 1);
  endtask

  task automatic test_many_columns();
    string s;
    s = "";
    for (int i = 0; i < 70; i++) s = {s, "1,"};
    send_text({s, "z\n"}, 1);
    send_text({s, "2.5\n"});
    drain();
  endtask

  function automatic string rand_cell();
    string pool[16] = '{"123", "-0", "1.5e-3", "0X1P4", "Infinity", "NaN", "abc", " 7 ",
                        "\"a,b\"", "\"\"", "99999999999999999999", "1 2", "\t.e", "0x",
                        "nan()", "-inf"};
    string s;
    int n;
    if ($urandom_range(0, 4) != 0) return pool[$urandom_range(0, 15)];
    s = "";
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(1, 255)))};
    return s;
  endfunction

  task automatic test_random(int budget);
    int sent;
    int cols;
    string line;
    sent = 0;
    while (sent < budget) begin
      cols = $urandom_range(1, 5);
      line = rand_cell();
      for (int c = 1; c < cols; c++) line = {line, ",", rand_cell()};
      if ($urandom_range(0, 19) == 0) begin
        send_text(line, $urandom_range(0, 9) == 0, 1);
      end else begin
        send_text({line, "\n"}, $urandom_range(0, 15) == 0, 0);
      end
      sent += line.len() + 1;
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    @(posedge clk);
    send_text("1,2,3\n4,5,6\n7,8,9\n");
    drain();
    send_text("x,y\n");
    drain();
  endtask

  initial begin
    errors = 0;
    cells_seen = 0;
    hold_cycles = 0;
    stress_on = 1;
    rst_n = 0;
    in_valid = 0;
    in_data_byte = 0;
    in_first_of_stream = 0;
    in_last_of_stream = 0;
    clear_stream();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_many_columns();
    test_backpressure();
    test_random(1040);
    send_byte(8'hFF, 0, 1);
    send_byte(8'h00, 1, 1);
    drain();
    $display("Covered quoting, numeric grammar, column saturation, stalls; %0d cells checked.",
             cells_seen);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
